FILE: src/mde_pkg.sv
// Shared types and constants for the MIPS decode and execute block.
// Holds the opcode and funct codes, decoded control types and port word structs.
// No dependencies.
`default_nettype none

package mde_pkg;

  // Primary opcodes, instruction bits [31:26].
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // Function codes of the SPECIAL opcode, instruction bits [5:0].
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_MOVN = 6'h0b;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  // REGIMM selectors in the rt field.
  localparam logic [4:0] RT_BLTZ   = 5'h00;
  localparam logic [4:0] RT_BGEZ   = 5'h01;
  localparam logic [4:0] RT_BLTZAL = 5'h10;
  localparam logic [4:0] RT_BGEZAL = 5'h11;

  typedef enum logic [3:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_XOR,
    ALU_NOR,
    ALU_SLT,
    ALU_SLTU,
    ALU_SLL,
    ALU_SRL,
    ALU_SRA,
    ALU_MOVN
  } alu_op_t;

  typedef enum logic [3:0] {
    BR_NONE,
    BR_JR,
    BR_JUMP,
    BR_BEQ,
    BR_BNE,
    BR_BLEZ,
    BR_BGTZ,
    BR_BLTZ,
    BR_BGEZ
  } br_kind_t;

  typedef struct packed {
    alu_op_t    alu_op;
    br_kind_t   br;
    logic       reg_write;
    logic       mem_load;
    logic       mem_write;
    logic       link_cond;
    logic [4:0] dest_reg;
  } ctl_t;

  typedef struct packed {
    logic        [31:0] instruction;
    logic signed [31:0] rs_value;
    logic signed [31:0] rt_value;
    logic        [29:0] next_pc;
  } issue_word_t;

  typedef struct packed {
    logic signed [31:0] alu_out;
    logic        [4:0]  dest_reg;
    logic               reg_write;
    logic               mem_load;
    logic               mem_write;
    logic signed [31:0] store_data;
    logic               branch_taken;
    logic        [29:0] branch_target;
    logic               link_write;
    logic        [29:0] link_value;
  } result_word_t;

endpackage

`default_nettype wire

FILE: src/mips_decode_execute.sv
// MIPS decode and execute block: control decode, ALU and branch resolution.
// Depends on mde_pkg for the port word structs, opcode codes and control types.
`default_nettype none

// Usage
// The issue channel carries one instruction word: the instruction, the
// already-forwarded rs and rt values and the word index of the next
// instruction. The result channel carries the decoded controls, the ALU
// result or memory address, store data and the resolved branch or jump.
// A word moves on either channel at a rising edge where valid is high and
// stall is low.
// Throughput is one word per cycle while the receiver does not stall: three
// register stages (decode, execute, format) each hold their own valid bit,
// and the deepest logic is the 32-bit adder and barrel shifter of the
// execute stage.
// When the receiver stalls, the result register holds its word unchanged
// and upstream stages keep moving until they fill up, so issue_stall rises
// only once every stage holds a word. Nothing is dropped or repeated.
// A synchronous reset empties all stages; no word is offered afterwards
// until new ones are issued.
module mips_decode_execute (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         issue_valid,
  output logic                        issue_stall,
  input  mde_pkg::issue_word_t        issue,
  output logic                        result_valid,
  input  wire                         result_stall,
  output mde_pkg::result_word_t       result
);

  // Stage handshake: a stage can take a word when it is empty or when
  // its own word moves on in the same cycle.
  logic s1_valid;
  logic s2_valid;
  logic ready1;
  logic ready2;
  logic ready3;

  assign ready3      = !result_valid || !result_stall;
  assign ready2      = !s2_valid || ready3;
  assign ready1      = !s1_valid || ready2;
  assign issue_stall = !ready1;

  // ---------------------------------------------------------------------
  // Stage 1: decode the instruction and select the second ALU operand.
  // ---------------------------------------------------------------------
  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [15:0] imm;
  logic [31:0] sx;
  logic        nop;
  logic        use_imm;
  logic        imm_zext;
  mde_pkg::ctl_t dec;

  assign op  = issue.instruction[31:26];
  assign fn  = issue.instruction[5:0];
  assign rt  = issue.instruction[20:16];
  assign imm = issue.instruction[15:0];
  assign sx  = {{16{imm[15]}}, imm};
  assign nop = (issue.instruction == 32'd0);

  always_comb begin
    dec.alu_op    = mde_pkg::ALU_NONE;
    dec.br        = mde_pkg::BR_NONE;
    dec.reg_write = 1'b0;
    dec.mem_load  = 1'b0;
    dec.mem_write = 1'b0;
    dec.link_cond = 1'b0;
    use_imm       = 1'b0;
    imm_zext      = 1'b0;
    // R-format writes rd, except jr; everything else names rt.
    dec.dest_reg  = (op == mde_pkg::OP_SPECIAL && fn != mde_pkg::FN_JR) ?
                    issue.instruction[15:11] : rt;
    if (!nop) begin
      unique case (op) inside
        mde_pkg::OP_SPECIAL: begin
          dec.reg_write = 1'b1;
          unique case (fn) inside
            mde_pkg::FN_JR: begin
              dec.reg_write = 1'b0;
              dec.br        = mde_pkg::BR_JR;
            end
            mde_pkg::FN_ADD, mde_pkg::FN_ADDU: dec.alu_op = mde_pkg::ALU_ADD;
            mde_pkg::FN_SUB:  dec.alu_op = mde_pkg::ALU_SUB;
            mde_pkg::FN_AND:  dec.alu_op = mde_pkg::ALU_AND;
            mde_pkg::FN_OR:   dec.alu_op = mde_pkg::ALU_OR;
            mde_pkg::FN_XOR:  dec.alu_op = mde_pkg::ALU_XOR;
            mde_pkg::FN_NOR:  dec.alu_op = mde_pkg::ALU_NOR;
            mde_pkg::FN_SLT:  dec.alu_op = mde_pkg::ALU_SLT;
            mde_pkg::FN_SLTU: dec.alu_op = mde_pkg::ALU_SLTU;
            mde_pkg::FN_SLL:  dec.alu_op = mde_pkg::ALU_SLL;
            mde_pkg::FN_SRL:  dec.alu_op = mde_pkg::ALU_SRL;
            mde_pkg::FN_SRA:  dec.alu_op = mde_pkg::ALU_SRA;
            mde_pkg::FN_MOVN: dec.alu_op = mde_pkg::ALU_MOVN;
            default:          dec.reg_write = 1'b0;
          endcase
        end
        mde_pkg::OP_LW, mde_pkg::OP_LBU, mde_pkg::OP_LHU: begin
          dec.reg_write = 1'b1;
          dec.mem_load  = 1'b1;
          dec.alu_op    = mde_pkg::ALU_ADD;
          use_imm       = 1'b1;
        end
        mde_pkg::OP_SH, mde_pkg::OP_SW: begin
          dec.mem_write = 1'b1;
          dec.alu_op    = mde_pkg::ALU_ADD;
          use_imm       = 1'b1;
        end
        mde_pkg::OP_BEQ:  dec.br = mde_pkg::BR_BEQ;
        mde_pkg::OP_BNE:  dec.br = mde_pkg::BR_BNE;
        mde_pkg::OP_BLEZ: dec.br = mde_pkg::BR_BLEZ;
        mde_pkg::OP_BGTZ: dec.br = mde_pkg::BR_BGTZ;
        mde_pkg::OP_REGIMM: begin
          unique case (rt) inside
            mde_pkg::RT_BLTZ, mde_pkg::RT_BLTZAL: dec.br = mde_pkg::BR_BLTZ;
            mde_pkg::RT_BGEZ, mde_pkg::RT_BGEZAL: dec.br = mde_pkg::BR_BGEZ;
            default:                              dec.br = mde_pkg::BR_NONE;
          endcase
          dec.link_cond = (rt == mde_pkg::RT_BLTZAL) || (rt == mde_pkg::RT_BGEZAL);
        end
        mde_pkg::OP_J:   dec.br = mde_pkg::BR_JUMP;
        mde_pkg::OP_JAL: begin
          dec.br        = mde_pkg::BR_JUMP;
          dec.link_cond = 1'b1;
        end
        mde_pkg::OP_ADDI, mde_pkg::OP_ADDIU: begin
          dec.reg_write = 1'b1;
          dec.alu_op    = mde_pkg::ALU_ADD;
          use_imm       = 1'b1;
        end
        mde_pkg::OP_ANDI: begin
          dec.reg_write = 1'b1;
          dec.alu_op    = mde_pkg::ALU_AND;
          use_imm       = 1'b1;
          imm_zext      = 1'b1;
        end
        mde_pkg::OP_ORI: begin
          dec.reg_write = 1'b1;
          dec.alu_op    = mde_pkg::ALU_OR;
          use_imm       = 1'b1;
          imm_zext      = 1'b1;
        end
        mde_pkg::OP_SLTI: begin
          dec.reg_write = 1'b1;
          dec.alu_op    = mde_pkg::ALU_SLT;
          use_imm       = 1'b1;
        end
        // sltiu compares unsigned against the sign-extended immediate.
        mde_pkg::OP_SLTIU: begin
          dec.reg_write = 1'b1;
          dec.alu_op    = mde_pkg::ALU_SLTU;
          use_imm       = 1'b1;
        end
        default: dec.br = mde_pkg::BR_NONE;
      endcase
    end
  end

  mde_pkg::ctl_t s1_ctl;
  logic [31:0]   s1_a;
  logic [31:0]   s1_b;
  logic [31:0]   s1_store;
  logic [29:0]   s1_npc;
  logic [29:0]   s1_offset;
  logic [4:0]    s1_shamt;
  logic [25:0]   s1_jidx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && issue_valid) begin
      s1_ctl    <= dec;
      s1_a      <= issue.rs_value;
      s1_b      <= !use_imm ? issue.rt_value : (imm_zext ? {16'd0, imm} : sx);
      s1_store  <= nop ? 32'd0 : issue.rt_value;
      s1_npc    <= issue.next_pc;
      s1_offset <= sx[29:0];
      s1_shamt  <= issue.instruction[10:6];
      s1_jidx   <= issue.instruction[25:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: ALU, branch condition and candidate targets.
  // ---------------------------------------------------------------------
  logic [31:0] res_next;
  logic        wr_next;
  logic        taken_next;
  logic [29:0] tgt_next;
  logic [29:0] npc_dec;

  assign npc_dec = s1_npc - 30'd1;

  always_comb begin
    wr_next = s1_ctl.reg_write;
    unique case (s1_ctl.alu_op)
      mde_pkg::ALU_ADD:  res_next = s1_a + s1_b;
      mde_pkg::ALU_SUB:  res_next = s1_a - s1_b;
      mde_pkg::ALU_AND:  res_next = s1_a & s1_b;
      mde_pkg::ALU_OR:   res_next = s1_a | s1_b;
      mde_pkg::ALU_XOR:  res_next = s1_a ^ s1_b;
      mde_pkg::ALU_NOR:  res_next = ~(s1_a | s1_b);
      mde_pkg::ALU_SLT:  res_next = {31'd0, ($signed(s1_a) < $signed(s1_b))};
      mde_pkg::ALU_SLTU: res_next = {31'd0, (s1_a < s1_b)};
      mde_pkg::ALU_SLL:  res_next = s1_b << s1_shamt;
      mde_pkg::ALU_SRL:  res_next = s1_b >> s1_shamt;
      mde_pkg::ALU_SRA:  res_next = $signed(s1_b) >>> s1_shamt;
      mde_pkg::ALU_MOVN: begin
        // A movn whose rt is zero moves nothing and writes nothing.
        res_next = (s1_b != 32'd0) ? s1_a : 32'd0;
        wr_next  = s1_ctl.reg_write && (s1_b != 32'd0);
      end
      default:           res_next = 32'd0;
    endcase
  end

  always_comb begin
    tgt_next = s1_npc + s1_offset;
    unique case (s1_ctl.br)
      mde_pkg::BR_JR: begin
        taken_next = 1'b1;
        tgt_next   = s1_a[29:0];
      end
      mde_pkg::BR_JUMP: begin
        taken_next = 1'b1;
        tgt_next   = {npc_dec[29:26], s1_jidx};
      end
      mde_pkg::BR_BEQ:  taken_next = (s1_a == s1_b);
      mde_pkg::BR_BNE:  taken_next = (s1_a != s1_b);
      mde_pkg::BR_BLEZ: taken_next = (s1_a == 32'd0) || s1_a[31];
      mde_pkg::BR_BGTZ: taken_next = (s1_a != 32'd0) && !s1_a[31];
      mde_pkg::BR_BLTZ: taken_next = s1_a[31];
      mde_pkg::BR_BGEZ: taken_next = !s1_a[31];
      default:          taken_next = 1'b0;
    endcase
  end

  logic [31:0] s2_res;
  logic        s2_wr;
  logic        s2_mem_load;
  logic        s2_mem_write;
  logic [4:0]  s2_dest;
  logic [31:0] s2_store;
  logic        s2_taken;
  logic [29:0] s2_tgt;
  logic        s2_link_cond;
  logic [29:0] s2_lval;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      s2_res       <= res_next;
      s2_wr        <= wr_next;
      s2_mem_load  <= s1_ctl.mem_load;
      s2_mem_write <= s1_ctl.mem_write;
      s2_dest      <= s1_ctl.dest_reg;
      s2_store     <= s1_store;
      s2_taken     <= taken_next;
      s2_tgt       <= tgt_next;
      s2_link_cond <= s1_ctl.link_cond;
      s2_lval      <= s1_npc + 30'd1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: zero the target and link fields when they do not apply and
  // hold the finished word for the receiver.
  // ---------------------------------------------------------------------
  mde_pkg::result_word_t result_next;
  logic                  link_next;

  assign link_next = s2_link_cond && s2_taken;

  always_comb begin
    result_next.alu_out       = s2_res;
    result_next.dest_reg      = s2_dest;
    result_next.reg_write     = s2_wr;
    result_next.mem_load      = s2_mem_load;
    result_next.mem_write     = s2_mem_write;
    result_next.store_data    = s2_store;
    result_next.branch_taken  = s2_taken;
    result_next.branch_target = s2_taken ? s2_tgt : 30'd0;
    result_next.link_write    = link_next;
    result_next.link_value    = link_next ? s2_lval : 30'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready3) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && s2_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire
